// ===== design/gprp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gprp_pkg;

  // Input request payload
  typedef struct packed {
    logic        [9:0]  point_x;
    logic        [9:0]  point_y;
    logic signed [15:0] point_z;
    logic        [23:0] point_color;
  } in_item_t;

  // Result request payload
  typedef struct packed {
    logic signed [23:0] screen_x;
    logic signed [23:0] screen_y;
    logic signed [23:0] view_depth;
    logic        [23:0] out_color;
  } out_item_t;

  // Sine and cosine in Q1.16
  typedef struct packed {
    logic signed [17:0] cos_pitch;
    logic signed [17:0] sin_pitch;
    logic signed [17:0] cos_yaw;
    logic signed [17:0] sin_yaw;
  } trig_t;

  // Geometry registers seen by the datapath
  typedef struct packed {
    logic        [10:0] grid_width;
    logic        [10:0] grid_height;
    logic signed [16:0] depth_sum;
    logic signed [7:0]  height_gain;
    logic        [15:0] zoom_scale;
  } geom_cfg_t;

  typedef enum logic [2:0] {
    REG_GRID_WIDTH    = 3'd0,
    REG_GRID_HEIGHT   = 3'd1,
    REG_DEPTH_SUM     = 3'd2,
    REG_ANGLE_X       = 3'd3,
    REG_ANGLE_Y       = 3'd4,
    REG_HEIGHT_GAIN   = 3'd5,
    REG_ZOOM_SCALE    = 3'd6,
    REG_RESERVED_MODE = 3'd7
  } reg_index_t;

  typedef enum logic {
    CS_IDLE,
    CS_RUN
  } cordic_state_t;

  localparam int CFG_DATA_W   = 17;
  localparam int CORDIC_STEPS = 15;
  localparam logic signed [18:0] CORDIC_START = 19'sd39797;

  // Reciprocal of ten: exact floor for numerators below 2^22
  localparam logic [19:0] DIV10_MUL   = 20'd838861;
  localparam int          DIV10_SHIFT = 23;
  // Rounding term plus a multiple of ten that keeps the numerator positive
  localparam logic signed [34:0] DIV_BIAS = 35'sd2684354565;
  localparam logic [29:0] DIV_BIAS_Q = 30'd268435456;

  // Arctangent of 2^-i in angle units
  function automatic logic [13:0] atan_units(input logic [3:0] step);
    logic [13:0] a;
    case (step)
      4'd0:    a = 14'd8192;
      4'd1:    a = 14'd4836;
      4'd2:    a = 14'd2555;
      4'd3:    a = 14'd1297;
      4'd4:    a = 14'd651;
      4'd5:    a = 14'd326;
      4'd6:    a = 14'd163;
      4'd7:    a = 14'd81;
      4'd8:    a = 14'd41;
      4'd9:    a = 14'd20;
      4'd10:   a = 14'd10;
      4'd11:   a = 14'd5;
      4'd12:   a = 14'd3;
      4'd13:   a = 14'd1;
      4'd14:   a = 14'd1;
      default: a = 14'd0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// ===== design/gprp_sincos.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gprp_sincos import gprp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        wr_x,
  input  wire logic        wr_y,
  input  wire logic [15:0] angle_x,
  input  wire logic [15:0] angle_y,
  output      logic        busy,
  output      trig_t       trig
);

  cordic_state_t      state_r, state_nxt;
  logic               pend_x_r, pend_x_nxt;
  logic               pend_y_r, pend_y_nxt;
  logic               sel_yaw_r, sel_yaw_nxt;
  logic [1:0]         quad_r, quad_nxt;
  logic [3:0]         i_r, i_nxt;
  logic signed [18:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [15:0] z_r, z_nxt;
  trig_t              trig_r, trig_nxt;

  logic signed [18:0] dx, dy, xs, ys;
  logic signed [15:0] zs, at;
  logic signed [17:0] c_val, s_val;

  // State register and pending flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= CS_IDLE;
      pend_x_r <= 1'b1;
      pend_y_r <= 1'b1;
    end else begin
      state_r  <= state_nxt;
      pend_x_r <= pend_x_nxt;
      pend_y_r <= pend_y_nxt;
    end
  end

  // Iteration registers
  always_ff @(posedge clk) begin
    sel_yaw_r <= sel_yaw_nxt;
    quad_r    <= quad_nxt;
    i_r       <= i_nxt;
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    z_r       <= z_nxt;
    trig_r    <= trig_nxt;
  end

  // One rotation step a cycle, then map by quadrant
  always_comb begin
    state_nxt   = state_r;
    pend_x_nxt  = pend_x_r;
    pend_y_nxt  = pend_y_r;
    sel_yaw_nxt = sel_yaw_r;
    quad_nxt    = quad_r;
    i_nxt       = i_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    z_nxt       = z_r;
    trig_nxt    = trig_r;

    dx = x_r >>> i_r;
    dy = y_r >>> i_r;
    at = 16'($signed({2'b00, atan_units(i_r)}));
    if (z_r >= 0) begin
      xs = x_r - dy;
      ys = y_r + dx;
      zs = z_r - at;
    end else begin
      xs = x_r + dy;
      ys = y_r - dx;
      zs = z_r + at;
    end

    case (quad_r)
      2'd0:    begin c_val = 18'(xs);  s_val = 18'(ys);  end
      2'd1:    begin c_val = 18'(-ys); s_val = 18'(xs);  end
      2'd2:    begin c_val = 18'(-xs); s_val = 18'(-ys); end
      default: begin c_val = 18'(ys);  s_val = 18'(-xs); end
    endcase

    case (state_r)
      CS_IDLE: begin
        if (pend_x_r || pend_y_r) begin
          sel_yaw_nxt = !pend_x_r;
          quad_nxt    = pend_x_r ? angle_x[15:14] : angle_y[15:14];
          z_nxt       = pend_x_r ? 16'($signed({2'b00, angle_x[13:0]}))
                                 : 16'($signed({2'b00, angle_y[13:0]}));
          x_nxt       = CORDIC_START;
          y_nxt       = '0;
          i_nxt       = '0;
          if (pend_x_r) pend_x_nxt = 1'b0;
          else          pend_y_nxt = 1'b0;
          state_nxt   = CS_RUN;
        end
      end
      CS_RUN: begin
        x_nxt = xs;
        y_nxt = ys;
        z_nxt = zs;
        i_nxt = i_r + 4'd1;
        if (i_r == 4'(CORDIC_STEPS - 1)) begin
          state_nxt = CS_IDLE;
          if (sel_yaw_r) begin
            trig_nxt.cos_yaw = c_val;
            trig_nxt.sin_yaw = s_val;
          end else begin
            trig_nxt.cos_pitch = c_val;
            trig_nxt.sin_pitch = s_val;
          end
        end
      end
      default: state_nxt = CS_IDLE;
    endcase

    // A fresh write always queues a recompute
    if (wr_x) pend_x_nxt = 1'b1;
    if (wr_y) pend_y_nxt = 1'b1;
  end

  assign busy = (state_r == CS_RUN) || pend_x_r || pend_y_r;
  assign trig = trig_r;

endmodule

`default_nettype wire

// ===== design/gprp_center.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gprp_center import gprp_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               in_v,
  input  wire in_item_t           in_d,
  input  wire geom_cfg_t          cfg,
  output      logic               v_o,
  output      logic signed [20:0] cx_o,
  output      logic signed [20:0] cy_o,
  output      logic signed [29:0] hz_o,
  output      logic [23:0]        color_o
);

  logic [3:0] v_r;
  logic signed [20:0] cx_r [4];
  logic signed [20:0] cy_r [4];
  logic [23:0]        col_r [4];
  logic signed [25:0] cz_r;
  logic [32:0]        b_r;
  logic [13:0]        qh_r;
  logic [3:0]         rh_r;
  logic [15:0]        lo_r;
  logic signed [29:0] hz_r;

  logic signed [11:0] gwm1, ghm1;
  logic signed [20:0] cx_nxt, cy_nxt;
  logic signed [25:0] cz_nxt;
  logic signed [33:0] dprod;
  logic signed [34:0] b_full;
  logic [36:0]        qh_prod;
  logic [16:0]        rh_full;
  logic [19:0]        n2;
  logic [39:0]        q2_prod;
  logic [29:0]        q_all;

  // Centre on the grid
  always_comb begin
    gwm1   = $signed({1'b0, cfg.grid_width}) - 12'sd1;
    ghm1   = $signed({1'b0, cfg.grid_height}) - 12'sd1;
    cx_nxt = 21'($signed({3'b000, in_d.point_x, 8'h00})) - (21'(gwm1) <<< 7);
    cy_nxt = 21'($signed({3'b000, in_d.point_y, 8'h00})) - (21'(ghm1) <<< 7);
    cz_nxt = (26'(in_d.point_z) <<< 8) - (26'(cfg.depth_sum) <<< 7);
  end

  // Height gain, biased so the divide works on a positive numerator
  always_comb begin
    dprod  = cz_r * cfg.height_gain;
    b_full = 35'(dprod) + DIV_BIAS;
  end

  // Divide by ten: upper half first, then remainder with lower half
  always_comb begin
    qh_prod = 37'(b_r[32:16]) * 37'(DIV10_MUL);
    rh_full = b_r[32:16] - 17'(qh_prod[36:DIV10_SHIFT]) * 17'd10;
    n2      = {rh_r, lo_r};
    q2_prod = 40'(n2) * 40'(DIV10_MUL);
    q_all   = {qh_r, q2_prod[38:DIV10_SHIFT]};
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], in_v};
    end
  end

  // Stage registers
  always_ff @(posedge clk) begin
    if (en) begin
      cx_r[0]  <= cx_nxt;
      cy_r[0]  <= cy_nxt;
      col_r[0] <= in_d.point_color;
      cz_r     <= cz_nxt;
      for (int k = 1; k < 4; k++) begin
        cx_r[k]  <= cx_r[k-1];
        cy_r[k]  <= cy_r[k-1];
        col_r[k] <= col_r[k-1];
      end
      b_r  <= b_full[32:0];
      qh_r <= qh_prod[36:DIV10_SHIFT];
      rh_r <= rh_full[3:0];
      lo_r <= b_r[15:0];
      hz_r <= $signed(q_all - DIV_BIAS_Q);
    end
  end

  assign v_o     = v_r[3];
  assign cx_o    = cx_r[3];
  assign cy_o    = cy_r[3];
  assign hz_o    = hz_r;
  assign color_o = col_r[3];

endmodule

`default_nettype wire

// ===== design/gprp_rotate.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gprp_rotate import gprp_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               v_i,
  input  wire logic signed [20:0] cx_i,
  input  wire logic signed [20:0] cy_i,
  input  wire logic signed [29:0] hz_i,
  input  wire logic [23:0]        color_i,
  input  wire trig_t              trig,
  output      logic               v_o,
  output      logic signed [31:0] rx_o,
  output      logic signed [32:0] ry_o,
  output      logic signed [32:0] rz_o,
  output      logic [23:0]        color_o
);

  logic [3:0] v_r;
  logic [23:0]        col_r [4];
  logic signed [20:0] cy_r [2];
  logic signed [31:0] rx_r [3];
  logic signed [38:0] p_cx_r, p_sc_r, q_cy_r, q_sy_r;
  logic signed [47:0] p_sh_r, p_ch_r;
  logic signed [49:0] q_st_r, q_ct_r;
  logic signed [31:0] tz_r;
  logic signed [32:0] ry_r, rz_r;

  logic signed [38:0] p_cx_nxt, p_sc_nxt, q_cy_nxt, q_sy_nxt;
  logic signed [47:0] p_sh_nxt, p_ch_nxt;
  logic signed [49:0] q_st_nxt, q_ct_nxt;
  logic signed [31:0] rx_nxt, tz_nxt;
  logic signed [32:0] ry_nxt, rz_nxt;

  // Yaw products, then yaw sums; pitch products, then pitch sums
  always_comb begin
    p_cx_nxt = trig.cos_yaw * cx_i;
    p_sh_nxt = trig.sin_yaw * hz_i;
    p_ch_nxt = trig.cos_yaw * hz_i;
    p_sc_nxt = trig.sin_yaw * cx_i;
    rx_nxt   = 32'((49'(p_cx_r) + 49'(p_sh_r) + 49'sd32768) >>> 16);
    tz_nxt   = 32'((49'(p_ch_r) - 49'(p_sc_r) + 49'sd32768) >>> 16);
    q_cy_nxt = trig.cos_pitch * cy_r[1];
    q_st_nxt = trig.sin_pitch * tz_r;
    q_sy_nxt = trig.sin_pitch * cy_r[1];
    q_ct_nxt = trig.cos_pitch * tz_r;
    ry_nxt   = 33'((51'(q_cy_r) - 51'(q_st_r) + 51'sd32768) >>> 16);
    rz_nxt   = 33'((51'(q_sy_r) + 51'(q_ct_r) + 51'sd32768) >>> 16);
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], v_i};
    end
  end

  // Stage registers
  always_ff @(posedge clk) begin
    if (en) begin
      col_r[0] <= color_i;
      for (int k = 1; k < 4; k++) col_r[k] <= col_r[k-1];
      cy_r[0] <= cy_i;
      cy_r[1] <= cy_r[0];
      p_cx_r  <= p_cx_nxt;
      p_sh_r  <= p_sh_nxt;
      p_ch_r  <= p_ch_nxt;
      p_sc_r  <= p_sc_nxt;
      rx_r[0] <= rx_nxt;
      rx_r[1] <= rx_r[0];
      rx_r[2] <= rx_r[1];
      tz_r    <= tz_nxt;
      q_cy_r  <= q_cy_nxt;
      q_st_r  <= q_st_nxt;
      q_sy_r  <= q_sy_nxt;
      q_ct_r  <= q_ct_nxt;
      ry_r    <= ry_nxt;
      rz_r    <= rz_nxt;
    end
  end

  assign v_o     = v_r[3];
  assign rx_o    = rx_r[2];
  assign ry_o    = ry_r;
  assign rz_o    = rz_r;
  assign color_o = col_r[3];

endmodule

`default_nettype wire

// ===== design/gprp_screen.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gprp_screen import gprp_pkg::*; #(
  parameter int unsigned SCREEN_OFFSET_X = 640,
  parameter int unsigned SCREEN_OFFSET_Y = 360
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               v_i,
  input  wire logic signed [31:0] rx_i,
  input  wire logic signed [32:0] ry_i,
  input  wire logic signed [32:0] rz_i,
  input  wire logic [23:0]        color_i,
  input  wire logic [15:0]        zoom_scale,
  output      logic               out_valid,
  output      out_item_t          out_data
);

  localparam logic signed [50:0] OFF_X = 51'(SCREEN_OFFSET_X) <<< 8;
  localparam logic signed [50:0] OFF_Y = 51'(SCREEN_OFFSET_Y) <<< 8;
  localparam logic signed [50:0] SAT_HI = 51'sd8388607;
  localparam logic signed [50:0] SAT_LO = -51'sd8388608;

  logic [1:0]         v_r;
  logic signed [49:0] zx_r, zy_r;
  logic signed [32:0] rz_r;
  logic [23:0]        col_r;
  out_item_t          out_r;

  logic signed [16:0] zs;
  logic signed [49:0] zx_nxt, zy_nxt;
  logic signed [50:0] sx, sy, sz;
  out_item_t          out_nxt;

  function automatic logic signed [23:0] sat24(input logic signed [50:0] v);
    logic signed [23:0] r;
    if (v > SAT_HI)      r = SAT_HI[23:0];
    else if (v < SAT_LO) r = SAT_LO[23:0];
    else                 r = v[23:0];
    return r;
  endfunction

  // Zoom products, then round, offset and saturate
  always_comb begin
    zs     = $signed({1'b0, zoom_scale});
    zx_nxt = rx_i * zs;
    zy_nxt = ry_i * zs;
    sx     = ((51'(zx_r) + 51'sd128) >>> 8) + OFF_X;
    sy     = ((51'(zy_r) + 51'sd128) >>> 8) + OFF_Y;
    sz     = 51'(rz_r);
    out_nxt.screen_x   = sat24(sx);
    out_nxt.screen_y   = sat24(sy);
    out_nxt.view_depth = sat24(sz);
    out_nxt.out_color  = col_r;
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[0], v_i};
    end
  end

  // Stage registers and output register
  always_ff @(posedge clk) begin
    if (en) begin
      zx_r  <= zx_nxt;
      zy_r  <= zy_nxt;
      rz_r  <= rz_i;
      col_r <= color_i;
      out_r <= out_nxt;
    end
  end

  assign out_valid = v_r[1];
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ===== design/grid_point_rotate_project.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Height-map point projector. One point request is taken per clock while
// the pipe advances and the sine/cosine unit is idle; its result leaves
// through a ten-stage pipeline (centring, gain and divide by ten over four
// stages, two rotations of two stages each, zoom and saturation over two);
// a stall on the result side with a valid result holds every stage. Writing
// angle_x or angle_y starts the shared sine/cosine unit, which loads each
// angle when idle, then runs 15 rotation steps; input is held off while it
// runs, and after reset while both reset-value angles are worked out.
module grid_point_rotate_project import gprp_pkg::*; #(
  parameter int unsigned SCREEN_OFFSET_X = 640,
  parameter int unsigned SCREEN_OFFSET_Y = 360
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output      logic                  in_stall,
  input  wire in_item_t              in_data,
  output      logic                  out_valid,
  input  wire logic                  out_stall,
  output      out_item_t             out_data,
  input  wire logic                  cfg_we,
  input  wire logic [2:0]            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  geom_cfg_t   geom_r;
  logic [15:0] angle_x_r, angle_y_r;
  logic        wr_x, wr_y, busy, en;
  trig_t       trig;

  logic               c_v;
  logic signed [20:0] c_cx, c_cy;
  logic signed [29:0] c_hz;
  logic [23:0]        c_col;
  logic               r_v;
  logic signed [31:0] r_rx;
  logic signed [32:0] r_ry, r_rz;
  logic [23:0]        r_col;

  // Configuration registers; the spare register has no effect and is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geom_r.grid_width  <= 11'd1;
      geom_r.grid_height <= 11'd1;
      geom_r.depth_sum   <= '0;
      geom_r.height_gain <= 8'sd10;
      geom_r.zoom_scale  <= 16'd256;
      angle_x_r          <= '0;
      angle_y_r          <= '0;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_GRID_WIDTH:    geom_r.grid_width  <= cfg_wdata[10:0];
        REG_GRID_HEIGHT:   geom_r.grid_height <= cfg_wdata[10:0];
        REG_DEPTH_SUM:     geom_r.depth_sum   <= $signed(cfg_wdata[16:0]);
        REG_ANGLE_X:       angle_x_r          <= cfg_wdata[15:0];
        REG_ANGLE_Y:       angle_y_r          <= cfg_wdata[15:0];
        REG_HEIGHT_GAIN:   geom_r.height_gain <= $signed(cfg_wdata[7:0]);
        REG_ZOOM_SCALE:    geom_r.zoom_scale  <= cfg_wdata[15:0];
        REG_RESERVED_MODE: ;
        default:           ;
      endcase
    end
  end

  assign wr_x = cfg_we && (reg_index_t'(cfg_index) == REG_ANGLE_X);
  assign wr_y = cfg_we && (reg_index_t'(cfg_index) == REG_ANGLE_Y);

  // Advance the whole pipe unless a finished result is held
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en || busy;

  gprp_sincos u_sincos (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_x    (wr_x),
    .wr_y    (wr_y),
    .angle_x (angle_x_r),
    .angle_y (angle_y_r),
    .busy    (busy),
    .trig    (trig)
  );

  gprp_center u_center (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (in_valid && !busy),
    .in_d    (in_data),
    .cfg     (geom_r),
    .v_o     (c_v),
    .cx_o    (c_cx),
    .cy_o    (c_cy),
    .hz_o    (c_hz),
    .color_o (c_col)
  );

  gprp_rotate u_rotate (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .v_i     (c_v),
    .cx_i    (c_cx),
    .cy_i    (c_cy),
    .hz_i    (c_hz),
    .color_i (c_col),
    .trig    (trig),
    .v_o     (r_v),
    .rx_o    (r_rx),
    .ry_o    (r_ry),
    .rz_o    (r_rz),
    .color_o (r_col)
  );

  gprp_screen #(
    .SCREEN_OFFSET_X (SCREEN_OFFSET_X),
    .SCREEN_OFFSET_Y (SCREEN_OFFSET_Y)
  ) u_screen (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .v_i        (r_v),
    .rx_i       (r_rx),
    .ry_i       (r_ry),
    .rz_i       (r_rz),
    .color_i    (r_col),
    .zoom_scale (geom_r.zoom_scale),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire
